// ===== rtl/macroblock_yuv420_to_rgba_defines.svh =====
// Assertion macros for the macroblock YCbCr 4:2:0 to RGBA converter.
// No dependencies; included by the top level, which supplies clk and rst.
`ifndef MACROBLOCK_YUV420_TO_RGBA_DEFINES_SVH
`define MACROBLOCK_YUV420_TO_RGBA_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MBY_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define MBY_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mby2r_pkg.sv =====
// Shared types and constants for the macroblock YCbCr 4:2:0 to RGBA converter.
// No dependencies.
package mby2r_pkg;

  localparam int BLOCK_SIDE_DEF = 16;
  localparam int CHROMA_WIDTH   = 16;

  localparam logic [7:0]         Y_BIAS    = 8'd16;
  localparam logic [15:0]        Y_COEF    = 16'h0095;
  localparam logic signed [17:0] RCR_COEF  = 18'sd204;
  localparam logic signed [17:0] GCR_COEF  = -18'sd104;
  localparam logic signed [17:0] GCB_COEF  = -18'sd50;
  localparam logic signed [17:0] BCB_COEF  = 18'sd258;
  localparam logic [7:0]         ALPHA_VAL = 8'h80;

  typedef struct packed {
    logic       kind;
    logic [3:0] row;
    logic [3:0] col;
    logic [7:0] luma;
    logic [7:0] blue_diff;
    logic [7:0] red_diff;
  } sample_t;

  typedef struct packed {
    logic [3:0] pix_row;
    logic [3:0] pix_col;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       block_done;
  } pixel_t;

  localparam logic KIND_CHROMA = 1'b0;
  localparam logic KIND_LUMA   = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic wr_en;     // write chroma pair into the store
    logic rd_en;     // start a luma item: read store, capture sample
    logic mul_en;    // register the products
    logic out_load;  // load the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic kind;
    logic chroma_ok;  // chroma position inside the store
    logic luma_ok;    // pixel position inside the block
  } dp_status_t;

endpackage

// ===== rtl/mby2r_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mby2r_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/mby2r_ctrl.sv =====
// Controller FSM: accept, store read, multiply, output load.
// Depends on mby2r_pkg.
module mby2r_ctrl
  import mby2r_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       sample_valid,
  output logic       sample_stall,
  output logic       pixel_valid,
  input  logic       pixel_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_MUL  = 3'b100
  } state_t;

  state_t state, state_next;
  logic   accept;
  logic   out_free;

  assign sample_stall = (state != S_IDLE);
  assign accept       = sample_valid && (state == S_IDLE);
  assign out_free     = !pixel_valid || !pixel_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.wr_en = accept && (status.kind == KIND_CHROMA) && status.chroma_ok;
        cmd.rd_en = accept && (status.kind == KIND_LUMA) && status.luma_ok;
        if (cmd.rd_en) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.mul_en = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.out_load = out_free;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pixel_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        pixel_valid <= 1'b1;
      end else if (!pixel_stall) begin
        pixel_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/mby2r_dp.sv =====
// Datapath: chroma store, coefficient products, rounding, clamp, output register.
// Depends on mby2r_pkg and mby2r_ram.
module mby2r_dp
  import mby2r_pkg::*;
#(
  parameter int BLOCK_SIDE = BLOCK_SIDE_DEF
) (
  input  logic       clk,
  input  sample_t    sample,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  output pixel_t     pixel
);

  localparam int CSIDE  = (BLOCK_SIDE + 1) / 2;
  localparam int CDEPTH = CSIDE * CSIDE;
  localparam int AW     = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;

  logic [11:0]             waddr_full, raddr_full;
  logic [CHROMA_WIDTH-1:0] rdata;
  logic [3:0]              row_q, col_q;
  logic [7:0]              luma_q;
  logic [7:0]              yb;
  logic signed [7:0]       cb_s, cr_s;
  logic signed [17:0]      cb_x, cr_x;
  logic [15:0]             lum_p;
  logic signed [17:0]      rcr_p, gcr_p, gcb_p, bcb_p;
  logic signed [11:0]      lum_s, r_sum, g_sum, b_sum;
  pixel_t                  pixel_next;

  function automatic logic [7:0] clamp8(input logic signed [11:0] v);
    logic [7:0] res;
    if (v < 12'sd0) begin
      res = 8'd0;
    end else if (v > 12'sd255) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  assign status.kind      = sample.kind;
  assign status.chroma_ok = (8'(sample.row) < 8'(CSIDE)) && (8'(sample.col) < 8'(CSIDE));
  assign status.luma_ok   = (8'(sample.row) < 8'(BLOCK_SIDE))
                         && (8'(sample.col) < 8'(BLOCK_SIDE));

  assign waddr_full = 12'(sample.row) * 12'(CSIDE) + 12'(sample.col);
  assign raddr_full = 12'(sample.row[3:1]) * 12'(CSIDE) + 12'(sample.col[3:1]);

  mby2r_ram #(
    .WIDTH (CHROMA_WIDTH),
    .DEPTH (CDEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (AW'(waddr_full)),
    .wdata ({sample.blue_diff, sample.red_diff}),
    .re    (cmd.rd_en),
    .raddr (AW'(raddr_full)),
    .rdata (rdata)
  );

  // Offset binary to two's complement: flip the top bit
  assign cb_s = $signed({~rdata[15], rdata[14:8]});
  assign cr_s = $signed({~rdata[7], rdata[6:0]});
  assign cb_x = 18'(cb_s);
  assign cr_x = 18'(cr_s);
  assign yb   = (luma_q < Y_BIAS) ? 8'd0 : (luma_q - Y_BIAS);

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      row_q  <= sample.row;
      col_q  <= sample.col;
      luma_q <= sample.luma;
    end
    if (cmd.mul_en) begin
      lum_p <= 16'(yb) * Y_COEF;
      rcr_p <= cr_x * RCR_COEF;
      gcr_p <= cr_x * GCR_COEF;
      gcb_p <= cb_x * GCB_COEF;
      bcb_p <= cb_x * BCB_COEF;
    end
    if (cmd.out_load) begin
      pixel <= pixel_next;
    end
  end

  // Bit slice [17:6] of a signed product is its floor shift by 6
  assign lum_s = $signed({2'b00, lum_p[15:6]});
  assign r_sum = lum_s + $signed(rcr_p[17:6]) + 12'sd1;
  assign g_sum = lum_s + $signed(gcr_p[17:6]) + $signed(gcb_p[17:6]) + 12'sd1;
  assign b_sum = lum_s + $signed(bcb_p[17:6]) + 12'sd1;

  always_comb begin
    pixel_next.pix_row    = row_q;
    pixel_next.pix_col    = col_q;
    pixel_next.red        = clamp8(r_sum >>> 1);
    pixel_next.green      = clamp8(g_sum >>> 1);
    pixel_next.blue       = clamp8(b_sum >>> 1);
    pixel_next.alpha      = ALPHA_VAL;
    pixel_next.block_done = (8'(row_q) == 8'(BLOCK_SIDE - 1))
                         && (8'(col_q) == 8'(BLOCK_SIDE - 1));
  end

endmodule

// ===== rtl/macroblock_yuv420_to_rgba.sv =====
// Macroblock YCbCr 4:2:0 to RGBA converter, BT.601 integer coefficients.
// Chroma item: written into the chroma store at the accept edge.
// Luma item: accept, store read + products, sum into output register; the output
// load waits while a finished pixel is stalled, and no new item enters until it is done.
// Reset (rst, sync, active high) clears the FSM and output valid; the chroma
// store is not cleared and holds undefined data until written.
`include "macroblock_yuv420_to_rgba_defines.svh"

module macroblock_yuv420_to_rgba
  import mby2r_pkg::*;
#(
  parameter int BLOCK_SIDE = BLOCK_SIDE_DEF  // pixels per block side, 2..16
) (
  input  logic    clk,
  input  logic    rst,
  // sample channel
  input  logic    sample_valid,
  output logic    sample_stall,
  input  sample_t sample,
  // pixel channel
  output logic    pixel_valid,
  input  logic    pixel_stall,
  output pixel_t  pixel
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Control: one luma item in flight; the output register lets the next
  // item enter while a finished pixel still waits downstream.
  mby2r_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .status       (status),
    .cmd          (cmd)
  );

  // Datapath: chroma store RAM, constant-coefficient products, round/clamp.
  mby2r_dp #(
    .BLOCK_SIDE (BLOCK_SIDE)
  ) u_dp (
    .clk    (clk),
    .sample (sample),
    .cmd    (cmd),
    .status (status),
    .pixel  (pixel)
  );

  // Store read leads straight into the product stage
  `MBY_ASSERT_NEXT(a_read_then_mul, cmd.rd_en, cmd.mul_en, "store read not followed by products")
  // A waiting pixel is never overwritten
  `MBY_ASSERT_NOW(a_no_overwrite, cmd.out_load, !pixel_valid || !pixel_stall, "pixel overwritten")
  // No new item is taken while products are being formed
  `MBY_ASSERT_NOW(a_busy_stall, cmd.mul_en, sample_stall, "sample taken during product stage")
  // A loaded pixel is offered on the next cycle
  `MBY_ASSERT_NEXT(a_load_valid, cmd.out_load, pixel_valid, "loaded pixel not offered")

endmodule

// ===== tb/rgba_pixel_checker.sv =====
// Watches the sample and pixel channels of the 4:2:0 to RGBA converter, predicts each pixel
// and compares it with the one the block delivers. Depends on mby2r_pkg for the item types.
module rgba_pixel_checker
  import mby2r_pkg::*;
#(
  parameter int SIDE = BLOCK_SIDE_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    sample_valid,
  input  logic    sample_stall,
  input  sample_t sample,
  input  logic    pixel_valid,
  input  logic    pixel_stall,
  input  pixel_t  pixel,
  output int      mismatches,
  output int      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int C_SIDE  = (SIDE + 1) / 2;
  localparam int C_DEPTH = C_SIDE * C_SIDE;

  // BT.601 integer coefficients, 7 fractional bits
  localparam int LUMA_GAIN = 149;
  localparam int CR_TO_R   = 204;
  localparam int CR_TO_G   = -104;
  localparam int CB_TO_G   = -50;
  localparam int CB_TO_B   = 258;
  localparam int Y_OFFSET  = 16;
  localparam int C_OFFSET  = 128;

  logic [15:0] cbcr_store [C_DEPTH];  // Cb high byte, Cr low byte
  pixel_t      pending_pixels [$];

  function automatic logic [7:0] clamp_byte(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  function automatic pixel_t convert_pixel(sample_t s);
    pixel_t      p;
    logic [15:0] pair;
    int          idx, yb, cb, cr, lum;
    idx  = (int'(s.row) >> 1) * C_SIDE + (int'(s.col) >> 1);
    pair = (idx < C_DEPTH) ? cbcr_store[idx] : 16'h0000;
    cb   = int'(pair[15:8]) - C_OFFSET;
    cr   = int'(pair[7:0]) - C_OFFSET;
    yb   = int'(s.luma) - Y_OFFSET;
    if (yb < 0) yb = 0;
    lum  = (LUMA_GAIN * yb) >>> 6;
    // int is signed, so >>> is a floor shift
    p.pix_row    = s.row;
    p.pix_col    = s.col;
    p.red        = clamp_byte((lum + ((CR_TO_R * cr) >>> 6) + 1) >>> 1);
    p.green      = clamp_byte((lum + ((CR_TO_G * cr) >>> 6) + ((CB_TO_G * cb) >>> 6) + 1) >>> 1);
    p.blue       = clamp_byte((lum + ((CB_TO_B * cb) >>> 6) + 1) >>> 1);
    p.alpha      = ALPHA_VAL;
    p.block_done = (int'(s.row) == SIDE - 1) && (int'(s.col) == SIDE - 1);
    return p;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: pixel %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      pending_pixels.delete();
      mismatches = 0;
    end else begin
      if (sample_valid && !sample_stall) begin
        if (sample.kind == KIND_CHROMA) begin
          if (int'(sample.row) < C_SIDE && int'(sample.col) < C_SIDE)
            cbcr_store[int'(sample.row) * C_SIDE + int'(sample.col)] =
              {sample.blue_diff, sample.red_diff};
        end else if (int'(sample.row) < SIDE && int'(sample.col) < SIDE) begin
          pending_pixels.push_back(convert_pixel(sample));
        end
      end
      if (pixel_valid && !pixel_stall) begin
        if (pending_pixels.size() == 0) begin
          $display("%0t: unexpected pixel, expected none, got row %0d col %0d", $time,
                   pixel.pix_row, pixel.pix_col);
          mismatches++;
        end else begin
          want = pending_pixels.pop_front();
          check_field("pix_row", want.pix_row, pixel.pix_row);
          check_field("pix_col", want.pix_col, pixel.pix_col);
          check_field("red", want.red, pixel.red);
          check_field("green", want.green, pixel.green);
          check_field("blue", want.blue, pixel.blue);
          check_field("alpha", want.alpha, pixel.alpha);
          check_field("block_done", want.block_done, pixel.block_done);
        end
      end
    end
    pending <= pending_pixels.size();
  end

endmodule

// ===== tb/tb_macroblock_yuv420_to_rgba.sv =====
// Top of the testbench for macroblock_yuv420_to_rgba: clock, reset, sample stimulus,
// pixel-side stall pattern and the verdict. Depends on mby2r_pkg and rgba_pixel_checker.
module tb_macroblock_yuv420_to_rgba
  import mby2r_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE        = BLOCK_SIDE_DEF;
  localparam int C_SIDE      = (SIDE + 1) / 2;
  localparam int HOLD_CYCLES = 300;        // long receiver hold-off, fills the pipe
  localparam int TAIL_CYCLES = 12;         // quiet time before the verdict
  localparam int CYCLE_LIMIT = 1_000_000;  // far beyond the slowest legal run

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    sample_valid = 1'b0;
  logic    sample_stall;
  sample_t sample = '0;
  logic    pixel_valid;
  logic    pixel_stall = 1'b0;
  pixel_t  pixel;

  int checker_errors;
  int pixels_pending;

  // Stimulus-side bookkeeping: which chroma entries hold data, so a luma item
  // never reads an entry that was never written.
  bit written [C_SIDE * C_SIDE];

  // Controls for the receiver process; only the stimulus writes these.
  logic calm = 1'b0;   // no idling on either side
  int   hold_req = 0;  // bump to ask for one long hold-off

  int cycle_count = 0;

  always #5 clk = ~clk;

  macroblock_yuv420_to_rgba #(.BLOCK_SIDE(SIDE)) DUT (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel)
  );

  rgba_pixel_checker #(.SIDE(SIDE)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .mismatches   (checker_errors),
    .pending      (pixels_pending)
  );

  // Idle length: mostly short, now and then long.
  function automatic int idle_len(bit allow_zero);
    int r;
    r = $urandom_range(99);
    if (allow_zero && r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 45);
  endfunction

  // Sample values biased toward the ends and the bias points of the math.
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 8'd0;
    if (r < 16) return 8'd255;
    if (r < 26) begin
      case ($urandom_range(7))
        0:       return 8'd15;
        1:       return 8'd16;
        2:       return 8'd17;
        3:       return 8'd127;
        4:       return 8'd128;
        5:       return 8'd129;
        6:       return 8'd235;
        default: return 8'd240;
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stall runs, plus one long hold-off on request. While calm
  // is set the random stall runs are off; a requested hold-off still stalls.
  // ---------------------------------------------------------------------------
  int run_left = 0;
  bit stalled = 1'b0;
  int hold_left = 0;
  int hold_seen = 0;

  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      pixel_stall <= 1'b1;
    end else begin
      if (run_left == 0) begin
        stalled  = ($urandom_range(99) < 30);
        run_left = stalled ? idle_len(1'b0) : $urandom_range(1, 12);
      end
      run_left--;
      pixel_stall <= stalled && !calm;
    end
  end

  // Hard stop if the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_macroblock_yuv420_to_rgba NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender. Valid stays high from one item to the next when there is no gap;
  // a stalled item holds its payload until accepted.
  // ---------------------------------------------------------------------------
  task automatic send(input sample_t s);
    int gap;
    gap = calm ? 0 : idle_len(1'b1);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    do @(posedge clk); while (sample_stall);
  endtask

  // Chroma write; the luma field is don't-care and gets random bits.
  task automatic send_chroma(int row, int col, logic [7:0] cb, logic [7:0] cr);
    sample_t s;
    s.kind      = KIND_CHROMA;
    s.row       = 4'(row);
    s.col       = 4'(col);
    s.luma      = 8'($urandom_range(255));
    s.blue_diff = cb;
    s.red_diff  = cr;
    // positions outside the chroma store are dropped by the block
    if (row < C_SIDE && col < C_SIDE) written[row * C_SIDE + col] = 1'b1;
    send(s);
  endtask

  // Luma item; Cb/Cr fields are don't-care and get random bits.
  task automatic send_luma(int row, int col, logic [7:0] y);
    sample_t s;
    s.kind      = KIND_LUMA;
    s.row       = 4'(row);
    s.col       = 4'(col);
    s.luma      = y;
    s.blue_diff = 8'($urandom_range(255));
    s.red_diff  = 8'($urandom_range(255));
    send(s);
  endtask

  // Drop valid and wait until every predicted pixel has come out.
  task automatic wait_drained();
    sample_valid <= 1'b0;
    do @(posedge clk); while (pixels_pending != 0);
  endtask

  // One well-formed macroblock: all 64 chroma pairs, then 256 pixels in raster
  // order, with an occasional dropped out-of-store chroma write mixed in.
  task automatic run_block(bit with_hold);
    for (int r = 0; r < C_SIDE; r++) begin
      for (int c = 0; c < C_SIDE; c++) begin
        if ($urandom_range(99) < 5)
          send_chroma($urandom_range(C_SIDE, 15), $urandom_range(15), pick_byte(), pick_byte());
        send_chroma(r, c, pick_byte(), pick_byte());
      end
    end
    for (int r = 0; r < SIDE; r++) begin
      for (int c = 0; c < SIDE; c++) begin
        // receiver goes quiet while the sender keeps pushing pixels
        if (with_hold && r == 2 && c == 8) hold_req <= hold_req + 1;
        send_luma(r, c, pick_byte());
      end
    end
  endtask

  initial begin
    int row, col;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // --- directed: coefficient extremes, luma bias edge, dropped writes ---
    send_chroma(0, 0, 8'd0, 8'd0);       // most negative Cb and Cr
    send_chroma(0, 1, 8'd255, 8'd255);   // most positive Cb and Cr
    send_chroma(0, 2, 8'd128, 8'd128);   // zero chroma: gray
    send_chroma(7, 7, 8'd0, 8'd255);
    send_chroma(7, 6, 8'd255, 8'd0);
    send_chroma(8, 3, 8'd77, 8'd200);    // outside the store, ignored
    send_chroma(2, 15, 8'd11, 8'd22);
    send_chroma(15, 15, 8'd255, 8'd255);
    send_luma(0, 0, 8'd0);               // Y below bias clamps to zero
    send_luma(1, 1, 8'd255);
    send_luma(0, 2, 8'd255);             // saturates high
    send_luma(1, 3, 8'd0);
    send_luma(0, 4, 8'd16);              // exactly at the luma bias
    send_luma(1, 5, 8'd15);
    send_luma(0, 5, 8'd17);
    send_luma(14, 14, 8'd128);
    send_luma(15, 15, 8'd255);           // last pixel of the block
    send_luma(15, 14, 8'd0);
    send_luma(14, 12, 8'd235);
    send_luma(15, 13, 8'd16);
    send_chroma(0, 2, 8'd127, 8'd129);   // rewrite; later pixels see the new pair
    send_luma(1, 4, 8'd200);
    send_luma(0, 5, 8'd255);

    // sender pauses until the pipe is empty
    wait_drained();

    // --- full macroblocks with random content ---
    run_block(1'b1);
    calm <= 1'b1;
    run_block(1'b0);
    calm <= 1'b0;
    run_block(1'b0);

    // --- noise: chroma rewrites and dropped writes among pixels in any order ---
    repeat (300) begin
      row = $urandom_range(15);
      col = $urandom_range(15);
      if ($urandom_range(3) == 0)
        send_chroma($urandom_range(9), $urandom_range(9), pick_byte(), pick_byte());
      else if (written[(row >> 1) * C_SIDE + (col >> 1)])
        send_luma(row, col, pick_byte());
      else
        send_chroma(row >> 1, col >> 1, pick_byte(), pick_byte());
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (checker_errors == 0 && pixels_pending == 0)
      $display("tb_macroblock_yuv420_to_rgba OK");
    else
      $display("tb_macroblock_yuv420_to_rgba NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/mby2r_pkg.sv
rtl/mby2r_ram.sv
rtl/mby2r_ctrl.sv
rtl/mby2r_dp.sv
rtl/macroblock_yuv420_to_rgba.sv
tb/rgba_pixel_checker.sv
tb/tb_macroblock_yuv420_to_rgba.sv
